FILE: sv/cbpd_pkg.sv
// Shared types and constants for the cubic Bezier point and derivative evaluator.
package cbpd_pkg;

   localparam int REG_W       = 60;
   localparam int NUM_REGS    = 4;
   localparam int NUM_AXES    = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int U_W         = 17;
   localparam int ORDER_IN_W  = 3;
   localparam int ORDER_W     = 2;
   localparam int MAX_ORDER   = 3;
   localparam int OUT_W       = 26;
   localparam int QUEUE_DEPTH = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 80;
   localparam int RSP_USER_W  = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CTRL_POINT_0 = 3'd0,
      CSR_CTRL_POINT_1 = 3'd1,
      CSR_CTRL_POINT_2 = 3'd2,
      CSR_CTRL_POINT_3 = 3'd3
   } csr_index_type;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] ctrl_regs_type;

   // Classification of one accepted item, carried with it through the queue.
   typedef struct packed {
      logic [ORDER_W-1:0] max_order;
      logic               err;
   } item_tag_type;

   // Tag of one result as it moves down the back end.
   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic               last;
      logic               err;
   } rsp_tag_type;

endpackage

FILE: sv/cubic_bezier_point_derivatives.sv
// Top level of the cubic Bezier point and derivative evaluator.
//
// Control points P0..P3 are written through the csr_ port (index 0..3, x/y/z
// packed as signed COORD_WIDTH-bit fields); writes to other indexes are dropped.
// Each req_ item carries u (curve_param) and the highest derivative order
// wanted; the block returns one rsp_ item per order 0..max_order, the last one
// with rsp_tlast set. A bad u or order yields one zeroed item with the error
// bit in rsp_tuser.
// After acceptance, the first result of an item passes three front stages, the
// queue, and three back stages before it shows on rsp_tvalid.
// The back end issues one order per cycle while the output is not stalled, so
// an item yields max_order+1 results (one for an error item); the front end
// takes one item per cycle into a four-entry queue unless back-pressure stalls it.
// Reset clears the control points, the pipeline valids and the queue.
// When rsp_tready is low the output register holds and the back end stalls;
// the four-entry queue fills, then the three front stages, and only then
// does req_tready drop.
module cubic_bezier_point_derivatives import cbpd_pkg::*; #(
   parameter int COORD_WIDTH     = 20,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // curve_param[16:0], max_order[19:17], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // deriv_order[1:0], deriv_x, deriv_y, deriv_z
   output logic                  rsp_tlast,
   output logic [RSP_USER_W-1:0] rsp_tuser,   // error_flag[0]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wdata
);

   localparam int ENTRY_W = 9 * (PARAM_FRAC_BITS + 1) + $bits(item_tag_type);

   ctrl_regs_type           ctrl_ff;
   logic                    fq_valid, fq_ready, bq_valid, bq_ready;
   logic [ENTRY_W-1:0]      fq_data, bq_data;
   rsp_tag_type             rsp_tag;
   logic signed [OUT_W-1:0] rsp_x, rsp_y, rsp_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CTRL_POINT_0: ctrl_ff[0] <= csr_wdata;
            CSR_CTRL_POINT_1: ctrl_ff[1] <= csr_wdata;
            CSR_CTRL_POINT_2: ctrl_ff[2] <= csr_wdata;
            CSR_CTRL_POINT_3: ctrl_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   cbpd_front #(
      .FRAC_BITS (PARAM_FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .curve_param (req_tdata[U_W-1:0]),
      .max_order   (req_tdata[U_W +: ORDER_IN_W]),
      .q_valid     (fq_valid),
      .q_ready     (fq_ready),
      .q_data      (fq_data)
   );

   cbpd_fifo #(
      .DATA_W (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   cbpd_back #(
      .COORD_W   (COORD_WIDTH),
      .FRAC_BITS (PARAM_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (bq_valid),
      .q_ready   (bq_ready),
      .q_data    (bq_data),
      .ctrl_regs (ctrl_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_tag   (rsp_tag),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_z     (rsp_z)
   );

   assign rsp_tdata = {rsp_z, rsp_y, rsp_x, rsp_tag.order};
   assign rsp_tlast = rsp_tag.last;
   assign rsp_tuser = RSP_USER_W'(rsp_tag.err);

endmodule

FILE: sv/cbpd_fifo.sv
// Short queue between the front end and the back end.
module cbpd_fifo import cbpd_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: sv/cbpd_front.sv
// Front end: accepts items, range-checks them and computes the Bernstein power terms.
module cbpd_front import cbpd_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_valid,
   output logic                                                  req_ready,
   input  logic [U_W-1:0]                                        curve_param,
   input  logic [ORDER_IN_W-1:0]                                 max_order,
   output logic                                                  q_valid,
   input  logic                                                  q_ready,
   output logic [9*(FRAC_BITS+1)+$bits(item_tag_type)-1:0]       q_data
);

   localparam int PW    = FRAC_BITS + 1;
   localparam int PW2   = 2 * PW;
   localparam int CMP_W = (U_W > PW) ? U_W : PW;

   localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;
   localparam logic [PW-1:0]    ONE_P   = PW'(1) << FRAC_BITS;
   localparam logic [PW2-1:0]   HALF_M  = PW2'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      item_tag_type    tag;
      logic [PW-1:0]   u, w, u2, w2, uw, u3, w3, uw2, u2w;
   } basis_type;

   // Rounded fixed-point product, both operands at most one.
   function automatic logic [PW-1:0] mulr(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW2-1:0] p;
      p = PW2'(a) * PW2'(b) + HALF_M;
      return PW'(p >> FRAC_BITS);
   endfunction

   logic                a_valid_ff, b_valid_ff, c_valid_ff;
   logic                a_rdy, b_rdy, c_rdy;
   logic [PW-1:0]       u_in, w_in;
   item_tag_type        tag_in;
   logic [PW-1:0]       a_u_ff, a_w_ff;
   item_tag_type        a_tag_ff;
   logic [PW-1:0]       b_u_ff, b_w_ff, b_u2_ff, b_w2_ff, b_uw_ff;
   item_tag_type        b_tag_ff;
   basis_type           c_in, c_basis_ff;

   assign c_rdy     = !c_valid_ff || q_ready;
   assign b_rdy     = !b_valid_ff || c_rdy;
   assign a_rdy     = !a_valid_ff || b_rdy;
   assign req_ready = a_rdy;
   assign q_valid   = c_valid_ff;
   assign q_data    = c_basis_ff;

   always_comb begin
      u_in              = PW'(curve_param);
      w_in              = ONE_P - u_in;
      tag_in.max_order  = ORDER_W'(max_order);
      tag_in.err        = (CMP_W'(curve_param) > ONE_CMP)
                          || (max_order > ORDER_IN_W'(MAX_ORDER));
   end

   always_comb begin
      c_in.tag = b_tag_ff;
      c_in.u   = b_u_ff;
      c_in.w   = b_w_ff;
      c_in.u2  = b_u2_ff;
      c_in.w2  = b_w2_ff;
      c_in.uw  = b_uw_ff;
      c_in.u3  = mulr(b_u2_ff, b_u_ff);
      c_in.w3  = mulr(b_w2_ff, b_w_ff);
      c_in.uw2 = mulr(b_u_ff, b_w2_ff);
      c_in.u2w = mulr(b_u2_ff, b_w_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_rdy) a_valid_ff <= req_valid;
         if (b_rdy) b_valid_ff <= a_valid_ff;
         if (c_rdy) c_valid_ff <= b_valid_ff;
      end
      if (a_rdy) begin
         a_u_ff   <= u_in;
         a_w_ff   <= w_in;
         a_tag_ff <= tag_in;
      end
      if (b_rdy) begin
         b_u_ff   <= a_u_ff;
         b_w_ff   <= a_w_ff;
         b_u2_ff  <= mulr(a_u_ff, a_u_ff);
         b_w2_ff  <= mulr(a_w_ff, a_w_ff);
         b_uw_ff  <= mulr(a_u_ff, a_w_ff);
         b_tag_ff <= a_tag_ff;
      end
      if (c_rdy) begin
         c_basis_ff <= c_in;
      end
   end

endmodule

FILE: sv/cbpd_back.sv
// Back end: steps through derivative orders, weights control points, rounds and sums.
module cbpd_back import cbpd_pkg::*; #(
   parameter int COORD_W   = 20,
   parameter int FRAC_BITS = 16
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  q_valid,
   output logic                                                  q_ready,
   input  logic [9*(FRAC_BITS+1)+$bits(item_tag_type)-1:0]       q_data,
   input  ctrl_regs_type                                         ctrl_regs,
   output logic                                                  rsp_valid,
   input  logic                                                  rsp_ready,
   output rsp_tag_type                                           rsp_tag,
   output logic signed [OUT_W-1:0]                               rsp_x,
   output logic signed [OUT_W-1:0]                               rsp_y,
   output logic signed [OUT_W-1:0]                               rsp_z
);

   localparam int PW     = FRAC_BITS + 1;
   localparam int WW     = FRAC_BITS + 6;
   localparam int PRW    = COORD_W + WW;
   localparam int RW     = PRW - FRAC_BITS;
   localparam int SW     = RW + 2;
   localparam int EW     = (SW > OUT_W) ? SW : OUT_W;
   localparam int FULL_W = (NUM_AXES * COORD_W > REG_W) ? NUM_AXES * COORD_W : REG_W;

   localparam logic signed [WW-1:0]  K2     = WW'(2);
   localparam logic signed [WW-1:0]  K3     = WW'(3);
   localparam logic signed [WW-1:0]  K6     = WW'(6);
   localparam logic signed [WW-1:0]  K18    = WW'(18);
   localparam logic signed [WW-1:0]  ONE_S  = WW'(1) << FRAC_BITS;
   localparam logic signed [PRW-1:0] HALF_P = PRW'(1) << (FRAC_BITS - 1);
   localparam logic signed [EW-1:0]  OMAX   = (EW'(1) << (OUT_W - 1)) - EW'(1);
   localparam logic signed [EW-1:0]  OMIN   = -OMAX - EW'(1);

   typedef struct packed {
      item_tag_type    tag;
      logic [PW-1:0]   u, w, u2, w2, uw, u3, w3, uw2, u2w;
   } basis_type;

   basis_type                head;
   logic [ORDER_W-1:0]       r_cnt_ff;
   logic                     last_now, issue;
   logic                     s0_rdy, s1_rdy, s2_rdy;
   logic signed [WW-1:0]     bu, bw, bu2, bw2, buw, bu3, bw3, buw2, bu2w;
   logic signed [WW-1:0]     w_in [NUM_REGS];
   rsp_tag_type              tag_in;

   logic                     s0_valid_ff;
   logic signed [WW-1:0]     s0_w_ff [NUM_REGS];
   rsp_tag_type              s0_tag_ff;

   logic [FULL_W-1:0]        full_regs [NUM_REGS];
   logic signed [COORD_W-1:0] coord [NUM_REGS][NUM_AXES];
   logic signed [PRW-1:0]    p_in [NUM_REGS][NUM_AXES];
   logic                     s1_valid_ff;
   logic signed [PRW-1:0]    s1_p_ff [NUM_REGS][NUM_AXES];
   rsp_tag_type              s1_tag_ff;

   logic signed [PRW-1:0]    t_rnd [NUM_REGS][NUM_AXES];
   logic signed [RW-1:0]     rnd [NUM_REGS][NUM_AXES];
   logic signed [SW-1:0]     acc [NUM_AXES];
   logic signed [EW-1:0]     acc_ext [NUM_AXES];
   logic signed [OUT_W-1:0]  c_in [NUM_AXES];
   logic                     s2_valid_ff;
   logic signed [OUT_W-1:0]  s2_c_ff [NUM_AXES];
   rsp_tag_type              s2_tag_ff;

   assign head     = q_data;
   assign last_now = head.tag.err || (r_cnt_ff == head.tag.max_order);
   assign s2_rdy   = !s2_valid_ff || rsp_ready;
   assign s1_rdy   = !s1_valid_ff || s2_rdy;
   assign s0_rdy   = !s0_valid_ff || s1_rdy;
   assign issue    = q_valid && s0_rdy;
   // The queue head stays put until its last order has been issued.
   assign q_ready  = s0_rdy && last_now;

   assign tag_in.order = r_cnt_ff;
   assign tag_in.last  = last_now;
   assign tag_in.err   = head.tag.err;

   always_comb begin
      bu   = WW'(head.u);
      bw   = WW'(head.w);
      bu2  = WW'(head.u2);
      bw2  = WW'(head.w2);
      buw  = WW'(head.uw);
      bu3  = WW'(head.u3);
      bw3  = WW'(head.w3);
      buw2 = WW'(head.uw2);
      bu2w = WW'(head.u2w);
      case (r_cnt_ff)
         2'd0: begin
            w_in[0] = bw3;
            w_in[1] = K3 * buw2;
            w_in[2] = K3 * bu2w;
            w_in[3] = bu3;
         end
         2'd1: begin
            w_in[0] = -(K3 * bw2);
            w_in[1] = K3 * (bw2 - K2 * buw);
            w_in[2] = K3 * (K2 * buw - bu2);
            w_in[3] = K3 * bu2;
         end
         2'd2: begin
            w_in[0] = K6 * bw;
            w_in[1] = -(K6 * (K2 * bw - bu));
            w_in[2] = K6 * (bw - K2 * bu);
            w_in[3] = K6 * bu;
         end
         2'd3: begin
            w_in[0] = -(K6 * ONE_S);
            w_in[1] = K18 * ONE_S;
            w_in[2] = -(K18 * ONE_S);
            w_in[3] = K6 * ONE_S;
         end
         default: begin
            w_in[0] = '0;
            w_in[1] = '0;
            w_in[2] = '0;
            w_in[3] = '0;
         end
      endcase
   end

   // Coordinate fields above the register width read as zero.
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         full_regs[i] = FULL_W'(ctrl_regs[i]);
         for (int k = 0; k < NUM_AXES; k++) begin
            coord[i][k] = $signed(full_regs[i][k*COORD_W +: COORD_W]);
            p_in[i][k]  = coord[i][k] * s0_w_ff[i];
         end
      end
   end

   // Round half up per product, exact sum, then clamp to the output range.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         acc[k] = '0;
         for (int i = 0; i < NUM_REGS; i++) begin
            t_rnd[i][k] = s1_p_ff[i][k] + HALF_P;
            rnd[i][k]   = t_rnd[i][k][PRW-1:FRAC_BITS];
            acc[k]      = acc[k] + SW'(rnd[i][k]);
         end
         acc_ext[k] = EW'(acc[k]);
         if (s1_tag_ff.err) begin
            c_in[k] = '0;
         end else if (acc_ext[k] > OMAX) begin
            c_in[k] = OUT_W'(OMAX);
         end else if (acc_ext[k] < OMIN) begin
            c_in[k] = OUT_W'(OMIN);
         end else begin
            c_in[k] = OUT_W'(acc_ext[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_cnt_ff    <= '0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            r_cnt_ff <= last_now ? '0 : r_cnt_ff + 1'b1;
         end
         if (s0_rdy) s0_valid_ff <= q_valid;
         if (s1_rdy) s1_valid_ff <= s0_valid_ff;
         if (s2_rdy) s2_valid_ff <= s1_valid_ff;
      end
      if (s0_rdy) begin
         s0_w_ff   <= w_in;
         s0_tag_ff <= tag_in;
      end
      if (s1_rdy) begin
         s1_p_ff   <= p_in;
         s1_tag_ff <= s0_tag_ff;
      end
      if (s2_rdy) begin
         s2_c_ff   <= c_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_tag   = s2_tag_ff;
   assign rsp_x     = s2_c_ff[0];
   assign rsp_y     = s2_c_ff[1];
   assign rsp_z     = s2_c_ff[2];

endmodule

FILE: sv/cbpd_checker.sv
// Port-level checker for the cubic Bezier evaluator, bound to the top level.
module cbpd_checker import cbpd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // An error result closes its run, with order zero and all coordinates zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("error result malformed");

   // The highest order always closes its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[ORDER_W-1:0] != ORDER_W'(MAX_ORDER))
      else $error("order three result not marked last");

   // Reset leaves the result channel empty and the input side open.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind cubic_bezier_point_derivatives cbpd_checker u_cbpd_checker (.*);
